/* sv/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define GHBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define GHBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ghbf_pkg.sv */
`default_nettype none

package ghbf_pkg;

  // Field and register widths
  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned CELL_SIZE_W = 16;
  localparam int unsigned GRID_DIM_W  = 7;
  localparam int unsigned HEIGHT_W    = 24;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_INDEX_W = 3;

  // Default grid store dimensions
  localparam int unsigned DEF_MAX_COLUMNS = 64;
  localparam int unsigned DEF_MAX_ROWS    = 64;

  // Register reset values
  localparam logic [CELL_SIZE_W-1:0] RST_CELL_SIZE_X = CELL_SIZE_W'(20480);
  localparam logic [CELL_SIZE_W-1:0] RST_CELL_SIZE_Y = CELL_SIZE_W'(20480);
  localparam logic [GRID_DIM_W-1:0]  RST_GRID_COLUMNS = GRID_DIM_W'(64);
  localparam logic [GRID_DIM_W-1:0]  RST_GRID_ROWS    = GRID_DIM_W'(64);
  localparam logic [HEIGHT_W-1:0]    RST_MIN_HEIGHT   = '0;
  localparam logic [HEIGHT_W-1:0]    RST_MAX_HEIGHT   = '1;

  // Operation codes
  localparam logic OP_GROUND   = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CELL_SIZE_X   = 3'd0,
    CFG_CELL_SIZE_Y   = 3'd1,
    CFG_GRID_COLUMNS  = 3'd2,
    CFG_GRID_ROWS     = 3'd3,
    CFG_MIN_HEIGHT    = 3'd4,
    CFG_MAX_HEIGHT    = 3'd5
  } cfg_index_t;

endpackage

`default_nettype wire

/* sv/ghbf_divider.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ghbf_divider #(
  parameter int unsigned DIVIDEND_W = ghbf_pkg::COORD_BITS,
  parameter int unsigned DIVISOR_W  = ghbf_pkg::CELL_SIZE_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       busy,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  run_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(DIVIDEND_W);
    end else if (run_r) begin
      run_r <= (cnt_r != CNT_W'(1));
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Datapath: quo_r holds the remaining dividend bits and the growing quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      if (fits) begin
        rem_r <= DIVISOR_W'(trial - {1'b0, div_r});
      end else begin
        rem_r <= trial[DIVISOR_W-1:0];
      end
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign busy     = run_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* sv/ghbf_cell_store.sv */
`default_nettype none

// Per-cell ground store: seen flags (cleared by a sweep after reset) and
// minimum heights (valid only where the seen flag is set).
module ghbf_cell_store #(
  parameter int unsigned DEPTH  = ghbf_pkg::DEF_MAX_COLUMNS * ghbf_pkg::DEF_MAX_ROWS,
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [ADDR_W-1:0]                    addr,
  input  wire logic                                 rd_en,
  input  wire logic                                 wr_en,
  input  wire logic signed [ghbf_pkg::COORD_BITS-1:0] wr_min,
  output logic                                      rd_seen,
  output logic signed [ghbf_pkg::COORD_BITS-1:0]    rd_min,
  output logic                                      clr_busy
);

  import ghbf_pkg::*;

  logic                         seen_mem [DEPTH];
  logic signed [COORD_BITS-1:0] min_mem  [DEPTH];

  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // Clearing sweep over the seen flags, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clearing_r <= (clr_cnt_r != ADDR_W'(DEPTH - 1));
      clr_cnt_r  <= clr_cnt_r + ADDR_W'(1);
    end
  end

  // Seen flags
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      seen_mem[clr_cnt_r] <= 1'b0;
    end else if (wr_en) begin
      seen_mem[addr] <= 1'b1;
    end
    if (rd_en) begin
      rd_seen <= seen_mem[addr];
    end
  end

  // Minimum heights
  always_ff @(posedge clk) begin
    if (wr_en) begin
      min_mem[addr] <= wr_min;
    end
    if (rd_en) begin
      rd_min <= min_mem[addr];
    end
  end

  assign clr_busy = clearing_r;

endmodule

`default_nettype wire

/* sv/grid_height_band_filter.sv */
// Grid height band filter.
// Input channel (in_valid/in_ready): one point per transaction with an operation
// code. Ground transactions fold the point's z into its grid cell's minimum;
// classify transactions emit the point on the output channel (out_valid/out_ready)
// when z minus that cell's minimum lies strictly between the two height limits.
// Points outside the configured grid, and classify points on an empty cell, give
// no output. The user writes configuration registers through cfg_we/cfg_index/
// cfg_wdata only while no transaction is in flight; the block does not enforce it.
// Points are handled one at a time. The column and row come from two restoring
// dividers running side by side at one bit a cycle, followed by an index stage and
// a read-modify-write of the cell memory.
// After reset all MAX_COLUMNS * MAX_ROWS seen flags (4096 by default) are swept
// clear with in_ready low; configuration writes still land.
// A finished result sits in an output register, so the next point is taken while
// it waits; only a second passing point stalls until out_ready frees the register.
`default_nettype none

module grid_height_band_filter #(
  parameter int unsigned MAX_COLUMNS = ghbf_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = ghbf_pkg::DEF_MAX_ROWS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Configuration
  input  wire logic                                   cfg_we,
  input  wire logic [ghbf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [ghbf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // Input channel
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_operation,
  input  wire logic [ghbf_pkg::COORD_BITS-1:0]        in_point_x,
  input  wire logic [ghbf_pkg::COORD_BITS-1:0]        in_point_y,
  input  wire logic signed [ghbf_pkg::COORD_BITS-1:0] in_point_z,
  // Output channel
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [ghbf_pkg::COORD_BITS-1:0]             out_kept_x,
  output logic [ghbf_pkg::COORD_BITS-1:0]             out_kept_y,
  output logic signed [ghbf_pkg::COORD_BITS-1:0]      out_kept_z
);

  import ghbf_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned DIFF_W     = COORD_BITS + 2;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_ADDR  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [CELL_SIZE_W-1:0] cell_size_x_r, cell_size_y_r;
  logic [GRID_DIM_W-1:0]  grid_columns_r, grid_rows_r;
  logic [HEIGHT_W-1:0]    min_height_r, max_height_r;

  // Point being processed
  logic                         op_r;
  logic [COORD_BITS-1:0]        px_r, py_r;
  logic signed [COORD_BITS-1:0] pz_r;
  logic [CELL_AW-1:0]           idx_r;
  logic signed [DIFF_W-1:0]     diff_r;

  // Output register
  logic                         out_valid_r;
  logic [COORD_BITS-1:0]        out_x_r, out_y_r;
  logic signed [COORD_BITS-1:0] out_z_r;

  logic                         accept;
  logic [CELL_SIZE_W-1:0]       div_x, div_y;
  logic                         x_busy, y_busy;
  logic [COORD_BITS-1:0]        col_q, row_q;
  logic [COORD_BITS-1:0]        col_lim, row_lim;
  logic                         in_grid;
  logic [CELL_AW-1:0]           idx_nxt;
  logic                         mem_rd, mem_wr;
  logic                         rd_seen, clr_busy;
  logic signed [COORD_BITS-1:0] rd_min;
  logic signed [DIFF_W-1:0]     diff_nxt;
  logic                         band_pass;
  logic                         out_free, out_load;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_x_r  <= RST_CELL_SIZE_X;
      cell_size_y_r  <= RST_CELL_SIZE_Y;
      grid_columns_r <= RST_GRID_COLUMNS;
      grid_rows_r    <= RST_GRID_ROWS;
      min_height_r   <= RST_MIN_HEIGHT;
      max_height_r   <= RST_MAX_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_SIZE_X:  cell_size_x_r  <= cfg_wdata[CELL_SIZE_W-1:0];
        CFG_CELL_SIZE_Y:  cell_size_y_r  <= cfg_wdata[CELL_SIZE_W-1:0];
        CFG_GRID_COLUMNS: grid_columns_r <= cfg_wdata[GRID_DIM_W-1:0];
        CFG_GRID_ROWS:    grid_rows_r    <= cfg_wdata[GRID_DIM_W-1:0];
        CFG_MIN_HEIGHT:   min_height_r   <= cfg_wdata[HEIGHT_W-1:0];
        CFG_MAX_HEIGHT:   max_height_r   <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // A zero cell size acts as one
  assign div_x = (cell_size_x_r == '0) ? CELL_SIZE_W'(1) : cell_size_x_r;
  assign div_y = (cell_size_y_r == '0) ? CELL_SIZE_W'(1) : cell_size_y_r;

  ghbf_divider #(
    .DIVIDEND_W (COORD_BITS),
    .DIVISOR_W  (CELL_SIZE_W)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_point_x),
    .divisor  (div_x),
    .busy     (x_busy),
    .quotient (col_q)
  );

  ghbf_divider #(
    .DIVIDEND_W (COORD_BITS),
    .DIVISOR_W  (CELL_SIZE_W)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (in_point_y),
    .divisor  (div_y),
    .busy     (y_busy),
    .quotient (row_q)
  );

  // Grid bounds: the smaller of the configured size and the store size
  assign col_lim = (COORD_BITS'(grid_columns_r) < COORD_BITS'(MAX_COLUMNS)) ?
                   COORD_BITS'(grid_columns_r) : COORD_BITS'(MAX_COLUMNS);
  assign row_lim = (COORD_BITS'(grid_rows_r) < COORD_BITS'(MAX_ROWS)) ?
                   COORD_BITS'(grid_rows_r) : COORD_BITS'(MAX_ROWS);
  assign in_grid = (col_q < col_lim) && (row_q < row_lim);

  // Cell index row * MAX_COLUMNS + column, taken modulo the address range
  assign idx_nxt = CELL_AW'(row_q) * CELL_AW'(MAX_COLUMNS) + CELL_AW'(col_q);

  // Cell memory access: one point in flight, so a write always lands before
  // the next read of any entry
  assign mem_rd = (state_r == S_READ);
  assign mem_wr = (state_r == S_CHECK) && (op_r == OP_GROUND) &&
                  (!rd_seen || (pz_r < rd_min));

  ghbf_cell_store #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (CELL_AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .addr     (idx_r),
    .rd_en    (mem_rd),
    .wr_en    (mem_wr),
    .wr_min   (pz_r),
    .rd_seen  (rd_seen),
    .rd_min   (rd_min),
    .clr_busy (clr_busy)
  );

  // Height above ground and band test
  assign diff_nxt  = {{2{pz_r[COORD_BITS-1]}}, pz_r} -
                     {{2{rd_min[COORD_BITS-1]}}, rd_min};
  assign band_pass = (diff_r > $signed({2'b00, min_height_r})) &&
                     (diff_r < $signed({2'b00, max_height_r}));

  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == S_EMIT) && band_pass && out_free;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (!clr_busy) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_DIV;
      S_DIV:   if (!x_busy && !y_busy) state_nxt = S_ADDR;
      S_ADDR:  state_nxt = in_grid ? S_READ : S_IDLE;
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = ((op_r == OP_CLASSIFY) && rd_seen) ? S_EMIT : S_IDLE;
      S_EMIT:  if (!band_pass || out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      px_r <= in_point_x;
      py_r <= in_point_y;
      pz_r <= in_point_z;
    end
    if (state_r == S_ADDR) begin
      idx_r <= idx_nxt;
    end
    if (state_r == S_CHECK) begin
      diff_r <= diff_nxt;
    end
    if (out_load) begin
      out_x_r <= px_r;
      out_y_r <= py_r;
      out_z_r <= pz_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kept_x = out_x_r;
  assign out_kept_y = out_y_r;
  assign out_kept_z = out_z_r;

  // Checks
  `GHBF_ASSERT_IMP(a_no_accept_while_clearing, clk, rst_n, clr_busy, !in_ready, "input taken during clearing sweep")
  `GHBF_ASSERT_IMP(a_write_only_ground, clk, rst_n, mem_wr, (state_r == S_CHECK) && (op_r == OP_GROUND), "cell write outside ground update")
  `GHBF_ASSERT_IMP(a_dividers_in_step, clk, rst_n, (state_r == S_DIV), (x_busy == y_busy), "dividers out of step")
  `GHBF_ASSERT_NXT(a_load_shows_valid, clk, rst_n, out_load, out_valid_r && (state_r == S_IDLE), "loaded result not presented")

endmodule

`default_nettype wire

/* tb/band_filter_checker.sv */
`default_nettype none

// Watches the configuration port and both channels, keeps its own copy of the
// grid ground store and compares every output transaction with the oldest kept point.
module band_filter_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic [ghbf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [ghbf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_ready,
  input  wire logic                                   in_operation,
  input  wire logic [ghbf_pkg::COORD_BITS-1:0]        in_point_x,
  input  wire logic [ghbf_pkg::COORD_BITS-1:0]        in_point_y,
  input  wire logic signed [ghbf_pkg::COORD_BITS-1:0] in_point_z,
  input  wire logic                                   out_valid,
  input  wire logic                                   out_ready,
  input  wire logic [ghbf_pkg::COORD_BITS-1:0]        out_kept_x,
  input  wire logic [ghbf_pkg::COORD_BITS-1:0]        out_kept_y,
  input  wire logic signed [ghbf_pkg::COORD_BITS-1:0] out_kept_z,
  output int                                          fail_count,
  output int                                          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ghbf_pkg::*;

  localparam int unsigned CELLS = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

  typedef struct packed {
    logic [COORD_BITS-1:0]        x;
    logic [COORD_BITS-1:0]        y;
    logic signed [COORD_BITS-1:0] z;
  } kept_point_t;

  // Register copy
  logic [CELL_SIZE_W-1:0] size_x, size_y;
  logic [GRID_DIM_W-1:0]  grid_cols, grid_rows;
  logic [HEIGHT_W-1:0]    band_lo, band_hi;

  // Ground store copy
  logic signed [COORD_BITS-1:0] ground_z [CELLS];
  bit                           ground_seen [CELLS];

  kept_point_t kept_points [$];

  // Fold a ground point into its cell, or queue a classify point that sits in the band
  task automatic filter_point(input logic op, input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py,
                              input logic signed [COORD_BITS-1:0] pz);
    int unsigned sx, sy, cols, rows, col, row, idx;
    logic signed [COORD_BITS+1:0] height;
    kept_point_t kp;
    sx   = (size_x == 0) ? 1 : size_x;
    sy   = (size_y == 0) ? 1 : size_y;
    cols = (grid_cols < DEF_MAX_COLUMNS) ? grid_cols : DEF_MAX_COLUMNS;
    rows = (grid_rows < DEF_MAX_ROWS) ? grid_rows : DEF_MAX_ROWS;
    col  = px / sx;
    row  = py / sy;
    if (col >= cols || row >= rows) return;
    idx = row * DEF_MAX_COLUMNS + col;
    if (op == OP_GROUND) begin
      if (!ground_seen[idx] || pz < ground_z[idx]) begin
        ground_z[idx]    = pz;
        ground_seen[idx] = 1'b1;
      end
    end else if (ground_seen[idx]) begin
      // wide enough that the difference never wraps
      height = pz - ground_z[idx];
      if (height > $signed({2'b00, band_lo}) && height < $signed({2'b00, band_hi})) begin
        kp.x = px;
        kp.y = py;
        kp.z = pz;
        kept_points = {kept_points, kp};
      end
    end
  endtask

  always @(posedge clk) begin
    kept_point_t exp_pt;
    if (!rst_n) begin
      size_x    = RST_CELL_SIZE_X;
      size_y    = RST_CELL_SIZE_Y;
      grid_cols = RST_GRID_COLUMNS;
      grid_rows = RST_GRID_ROWS;
      band_lo   = RST_MIN_HEIGHT;
      band_hi   = RST_MAX_HEIGHT;
      for (int i = 0; i < CELLS; i++) ground_seen[i] = 1'b0;
      kept_points.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELL_SIZE_X:  size_x    = cfg_wdata[CELL_SIZE_W-1:0];
          CFG_CELL_SIZE_Y:  size_y    = cfg_wdata[CELL_SIZE_W-1:0];
          CFG_GRID_COLUMNS: grid_cols = cfg_wdata[GRID_DIM_W-1:0];
          CFG_GRID_ROWS:    grid_rows = cfg_wdata[GRID_DIM_W-1:0];
          CFG_MIN_HEIGHT:   band_lo   = cfg_wdata[HEIGHT_W-1:0];
          CFG_MAX_HEIGHT:   band_hi   = cfg_wdata[HEIGHT_W-1:0];
          default: ;
        endcase
      end

      // input transaction
      if (in_valid && in_ready)
        filter_point(in_operation, in_point_x, in_point_y, in_point_z);

      // output transaction
      if (out_valid && out_ready) begin
        if (kept_points.size() == 0) begin
          $error("unexpected output transaction: x=%0d y=%0d z=%0d",
                 out_kept_x, out_kept_y, out_kept_z);
          fail_count++;
        end else begin
          exp_pt = kept_points.pop_front();
          if (out_kept_x !== exp_pt.x) begin
            $error("kept_x: expected %0d, actual %0d", exp_pt.x, out_kept_x);
            fail_count++;
          end
          if (out_kept_y !== exp_pt.y) begin
            $error("kept_y: expected %0d, actual %0d", exp_pt.y, out_kept_y);
            fail_count++;
          end
          if (out_kept_z !== exp_pt.z) begin
            $error("kept_z: expected %0d, actual %0d", exp_pt.z, out_kept_z);
            fail_count++;
          end
        end
      end
    end
    pending_count = kept_points.size();
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ghbf_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_INDEX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_operation;
  logic [COORD_BITS-1:0]         in_point_x;
  logic [COORD_BITS-1:0]         in_point_y;
  logic signed [COORD_BITS-1:0]  in_point_z;
  logic                          out_valid;
  logic                          out_ready;
  logic [COORD_BITS-1:0]         out_kept_x;
  logic [COORD_BITS-1:0]         out_kept_y;
  logic signed [COORD_BITS-1:0]  out_kept_z;

  int fail_count;
  int pending_count;
  int stall_cycles = 0;

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  // grid geometry currently programmed, for aiming points at cells
  int unsigned grid_sx, grid_sy, grid_nx, grid_ny;

  grid_height_band_filter u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kept_x   (out_kept_x),
    .out_kept_y   (out_kept_y),
    .out_kept_z   (out_kept_z)
  );

  band_filter_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kept_x    (out_kept_x),
    .out_kept_y    (out_kept_y),
    .out_kept_z    (out_kept_z),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: too long with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random back-pressure bursts, plus one long hold when asked
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 14);
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // One input transaction, optionally preceded by an idle burst
  task automatic send_point(input logic op, input logic [COORD_BITS-1:0] px,
                            input logic [COORD_BITS-1:0] py,
                            input logic [COORD_BITS-1:0] pz);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation = op;
    in_point_x   = px;
    in_point_y   = py;
    in_point_z   = pz;
    in_valid     = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and let every kept point and any in-flight point come out
  task automatic drain();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned sx, input int unsigned sy,
                              input int unsigned nx, input int unsigned ny,
                              input int unsigned lo, input int unsigned hi);
    write_reg(CFG_CELL_SIZE_X, CFG_DATA_W'(sx));
    write_reg(CFG_CELL_SIZE_Y, CFG_DATA_W'(sy));
    write_reg(CFG_GRID_COLUMNS, CFG_DATA_W'(nx));
    write_reg(CFG_GRID_ROWS, CFG_DATA_W'(ny));
    write_reg(CFG_MIN_HEIGHT, CFG_DATA_W'(lo));
    write_reg(CFG_MAX_HEIGHT, CFG_DATA_W'(hi));
    cfg_we  = 1'b0;
    // a zero size acts as one, and the store caps the grid
    grid_sx = (sx == 0) ? 1 : sx;
    grid_sy = (sy == 0) ? 1 : sy;
    grid_nx = (nx < DEF_MAX_COLUMNS) ? nx : DEF_MAX_COLUMNS;
    grid_ny = (ny < DEF_MAX_ROWS) ? ny : DEF_MAX_ROWS;
  endtask

  // Coordinate inside a random cell, now and then one cell past the edge
  function automatic logic [COORD_BITS-1:0] grid_coord(input int unsigned size,
                                                       input int unsigned cells);
    int unsigned slot;
    slot = ($urandom_range(0, 15) == 0) ? cells : $urandom_range(0, cells - 1);
    return COORD_BITS'(slot * size + $urandom_range(0, size - 1));
  endfunction

  // Ground pass then classify pass over the current grid, with some noise mixed in
  task automatic run_phase(input int n_ground, input int n_classify,
                           input int z_base, input int z_span, input bit hold);
    int span;
    for (int k = 0; k < n_ground + n_classify; k++) begin
      if (hold && k == n_ground) hold_req = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_point(1'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom));
      end else begin
        span = (k < n_ground) ? z_span : 2 * z_span;
        send_point((k < n_ground) ? OP_GROUND : OP_CLASSIFY,
                   grid_coord(grid_sx, grid_nx), grid_coord(grid_sy, grid_ny),
                   COORD_BITS'(z_base + int'($urandom_range(0, span))));
      end
    end
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_operation = OP_GROUND;
    in_point_x   = '0;
    in_point_y   = '0;
    in_point_z   = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed part on the reset configuration
    send_point(OP_GROUND, 0, 0, 0);
    send_point(OP_GROUND, 0, 0, 24'h800000);
    send_point(OP_CLASSIFY, 0, 0, 24'h7FFFFF);      // full-scale height hits upper limit
    send_point(OP_CLASSIFY, 0, 0, 24'h7FFFFE);
    send_point(OP_CLASSIFY, 0, 0, 24'h800000);      // zero height, not above lower limit
    send_point(OP_CLASSIFY, 20479, 20479, 24'h800001);
    send_point(OP_CLASSIFY, 20480, 0, 100);         // empty cell
    send_point(OP_GROUND, 1310719, 1310719, 24'h7FFFFF);
    send_point(OP_CLASSIFY, 1310719, 1310719, 24'h7FFFFF);
    send_point(OP_GROUND, 1310720, 0, 0);           // just outside the grid
    send_point(OP_CLASSIFY, 1310720, 0, 5);
    send_point(OP_GROUND, 24'hFFFFFF, 24'hFFFFFF, 24'h800000);
    send_point(OP_CLASSIFY, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF);
    send_point(OP_GROUND, 102407, 61440, 1000);
    send_point(OP_GROUND, 102400, 81919, 2000);     // higher, minimum stays
    send_point(OP_CLASSIFY, 122879, 70000, 1500);
    send_point(OP_CLASSIFY, 102400, 61440, 999);    // below ground
    send_point(OP_GROUND, 0, 1310719, 24'hFFFFFF);
    send_point(OP_CLASSIFY, 5, 1310000, 24'h7FFFFF);
    drain();

    // Zero cell sizes act as one
    set_geometry(0, 0, 6, 6, 0, 24'hFFFFFF);
    run_phase(60, 90, -1000, 3000, 1'b0);
    drain();

    // Largest cells, single-cell grid, lowest heights
    set_geometry(65535, 65535, 1, 1, 10, 3000);
    run_phase(40, 80, -8388608, 2000, 1'b0);
    drain();

    // Grid dimensions above the store size are capped
    set_geometry(4096, 1000, 127, 100, 0, 24'hFFFFFF);
    run_phase(60, 60, 0, 100000, 1'b0);
    drain();

    // Equal limits: nothing passes
    set_geometry(300, 700, 8, 5, 5000, 5000);
    run_phase(40, 60, 1000, 10000, 1'b0);
    drain();

    // Both limits at full scale, heights near the top
    set_geometry(1234, 4321, 20, 30, 24'hFFFFFF, 24'hFFFFFF);
    run_phase(30, 40, 8388607 - 30000, 10000, 1'b0);
    drain();

    // Long output hold while points keep coming
    set_geometry(1000, 1000, 4, 4, 0, 100000);
    run_phase(40, 120, -50000, 20000, 1'b1);
    drain();

    // Last stretch at full rate on both sides
    no_idle = 1'b1;
    set_geometry(2000, 2000, 8, 8, 200, 60000);
    run_phase(100, 160, 0, 50000, 1'b0);
    drain();

    if (fail_count == 0 && pending_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
